// File: rtl/core/dtw_pkg.sv
// shared types and constants for the dtw distance unit
`timescale 1ns / 1ps
`default_nettype none
package dtw_pkg;
  localparam int MaxLen = 32;
  localparam int IdxW = $clog2(MaxLen);
  localparam int CntW = IdxW + 1;
  localparam int PathLen = 2 * MaxLen - 1;
  localparam int PathW = $clog2(PathLen);
  localparam logic [23:0] Sat24 = 24'hFFFFFF;

  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] MK_START = 2'd0;
  localparam logic [1:0] MK_LEFT = 2'd1;
  localparam logic [1:0] MK_UP = 2'd2;
  localparam logic [1:0] MK_DIAG = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic [4:0] index_first;
    logic [4:0] index_second;
    logic [23:0] distance;
    logic [1:0] status;
    logic last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SQ, S_SQRT, S_ACC, S_BT_RD, S_BT, S_EMIT, S_FINAL
  } state_t;

  // request to the square root unit and its answer
  typedef struct packed {
    logic start;
    logic [32:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic done;
    logic [16:0] root;
  } sqrt_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/dtw_isqrt.sv
// bit-pair serial floor integer square root, two result bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module dtw_isqrt import dtw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  sqrt_req_t      req,
  output sqrt_rsp_t      rsp
);
  logic [33:0] rem_r, rem_nxt;
  logic [33:0] root_r, root_nxt;
  logic [33:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // each cycle runs two steps of the classic bit-pair recurrence
  always_comb begin
    logic [33:0] rm, rt, bt;
    rm = rem_r;
    rt = root_r;
    bt = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rm = {1'b0, req.value};
      rt = '0;
      bt = 34'h1 << 32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int s = 0; s < 2; s++) begin
        if (bt != '0) begin
          if (rm >= rt + bt) begin
            rm = rm - (rt + bt);
            rt = (rt >> 1) + bt;
          end else begin
            rt = rt >> 1;
          end
          bt = bt >> 2;
        end
      end
      if (bt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    rem_nxt = rm;
    root_nxt = rt;
    bit_nxt = bt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r[16:0];
endmodule
`default_nettype wire

// File: rtl/core/dtw_curve_distance_with_path_unit.sv
// dtw distance unit top level: point stores, cost grid walk, backtrack
`timescale 1ns / 1ps
`default_nettype none
// a load leaves busy low; a point transaction can follow every cycle
// compute: each of the n1*n2 grid cells passes read, square and root start, root wait, add;
// then, with emit_path set, a backtrack (mark read, step) and the path; then the distance
// the root unit sets the cell time; results go out one per cycle, the receiver cannot stall
// synchronous active-low reset clears counts, overflow flag, emit_path to 1
// point, cost, mark and path memories need no clearing pass
module dtw_curve_distance_with_path_unit import dtw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);
  // memories
  logic [31:0] mem_a [MaxLen];
  logic [31:0] mem_b [MaxLen];
  logic [23:0] mem_cost [2*MaxLen];
  logic [1:0]  mem_mark [MaxLen*MaxLen];
  logic [2*IdxW-1:0] mem_path [PathLen];

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_a_r, cnt_b_r, n1_r, n2_r;
  logic            ovf_r, emit_r, st_ovf_r;
  logic [IdxW-1:0] i_r, j_r;
  logic [23:0]     left_r, diag_r;
  logic [23:0]     dist_r, up_q;
  logic [1:0]      mark_q;
  logic [31:0]     pa_q, pb_q;
  logic [PathW:0]  plen_r;
  logic [2*IdxW-1:0] path_q;
  logic [PathW-1:0]  path_rd;
  sqrt_req_t sreq;
  sqrt_rsp_t srsp;

  wire accept = start && !busy;
  wire last_cell = ({1'b0, i_r} == n1_r - 1'b1) && ({1'b0, j_r} == n2_r - 1'b1);

  dtw_isqrt u_sqrt (.clk, .rst_n, .req(sreq), .rsp(srsp));

  assign busy = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  // path read address runs one entry ahead while emitting
  always_comb begin
    path_rd = plen_r[PathW-1:0] - 1'b1;
    if (state_r == S_EMIT) path_rd = plen_r[PathW-1:0] - PathW'(2);
    if (path_rd >= PathW'(PathLen)) path_rd = '0;
  end

  // point loads and registered memory reads
  always_ff @(posedge clk) begin
    if (accept && in_item.kind == KIND_FIRST && !cnt_a_r[IdxW])
      mem_a[cnt_a_r[IdxW-1:0]] <= {in_item.coord_x, in_item.coord_y};
    if (accept && in_item.kind == KIND_SECOND && !cnt_b_r[IdxW])
      mem_b[cnt_b_r[IdxW-1:0]] <= {in_item.coord_x, in_item.coord_y};
    pa_q <= mem_a[i_r];
    pb_q <= mem_b[j_r];
    up_q <= mem_cost[{~i_r[0], j_r}];
    mark_q <= mem_mark[{i_r, j_r}];
    path_q <= mem_path[path_rd];
  end

  // cell arithmetic
  logic signed [16:0] dx, dy;
  logic [31:0] sq_x, sq_y;
  logic [23:0] root24, base, sum;
  logic [24:0] sum_w;
  logic [1:0]  mark;
  always_comb begin
    // point reads are valid from the cycle after S_RD on
    dx = $signed({pa_q[31], pa_q[31:16]}) - $signed({pb_q[31], pb_q[31:16]});
    dy = $signed({pa_q[15], pa_q[15:0]}) - $signed({pb_q[15], pb_q[15:0]});
    sq_x = 32'(dx * dx);
    sq_y = 32'(dy * dy);
    root24 = {7'd0, srsp.root};
    if (i_r == '0 && j_r == '0) begin
      base = '0; mark = MK_START;
    end else if (i_r == '0) begin
      base = left_r; mark = MK_LEFT;
    end else if (j_r == '0) begin
      base = up_q; mark = MK_UP;
    end else if (left_r <= up_q && left_r <= diag_r) begin
      base = left_r; mark = MK_LEFT;
    end else if (up_q <= diag_r) begin
      base = up_q; mark = MK_UP;
    end else begin
      base = diag_r; mark = MK_DIAG;
    end
    sum_w = {1'b0, base} + {1'b0, root24};
    sum = sum_w[24] ? Sat24 : sum_w[23:0];
  end

  assign sreq.start = state_r == S_SQ;
  assign sreq.value = {1'b0, sq_x} + {1'b0, sq_y};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_item.kind == KIND_COMPUTE)
        state_nxt = (cnt_a_r == '0 || cnt_b_r == '0) ? S_FINAL : S_RD;
      S_RD: state_nxt = S_SQ;
      S_SQ: state_nxt = S_SQRT;
      S_SQRT: if (srsp.done) state_nxt = S_ACC;
      S_ACC: state_nxt = last_cell ? (emit_r ? S_BT_RD : S_FINAL) : S_RD;
      S_BT_RD: state_nxt = S_BT;
      S_BT: begin
        if (plen_r == (PathW+1)'(PathLen) || (mark_q == MK_LEFT && j_r == '0) ||
            (mark_q == MK_UP && i_r == '0) || mark_q == MK_START ||
            (mark_q == MK_DIAG && (i_r == '0 || j_r == '0)))
          state_nxt = S_EMIT;
        else
          state_nxt = S_BT_RD;
      end
      S_EMIT: if (plen_r == (PathW+1)'(1)) state_nxt = S_FINAL;
      S_FINAL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r <= 1'b0;
      emit_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) emit_r <= cfg_data;
      if (accept) begin
        case (in_item.kind)
          KIND_FIRST: if (cnt_a_r[IdxW]) ovf_r <= 1'b1; else cnt_a_r <= cnt_a_r + 1'b1;
          KIND_SECOND: if (cnt_b_r[IdxW]) ovf_r <= 1'b1; else cnt_b_r <= cnt_b_r + 1'b1;
          KIND_COMPUTE: begin
            cnt_a_r <= '0;
            cnt_b_r <= '0;
            ovf_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers and memory writes
  always_ff @(posedge clk) begin
    if (accept && in_item.kind == KIND_COMPUTE) begin
      n1_r <= cnt_a_r;
      n2_r <= cnt_b_r;
      st_ovf_r <= ovf_r;
      i_r <= '0;
      j_r <= '0;
      dist_r <= '0;
    end
    if (state_r == S_ACC) begin
      mem_cost[{i_r[0], j_r}] <= sum;
      mem_mark[{i_r, j_r}] <= mark;
      diag_r <= up_q;
      left_r <= sum;
      if (last_cell) begin
        dist_r <= sum;
        mem_path[0] <= {i_r, j_r};
        plen_r <= (PathW+1)'(1);
      end else if ({1'b0, j_r} == n2_r - 1'b1) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
    if (state_r == S_BT && state_nxt == S_BT_RD) begin
      if (mark_q == MK_LEFT) j_r <= j_r - 1'b1;
      else if (mark_q == MK_UP) i_r <= i_r - 1'b1;
      else begin
        i_r <= i_r - 1'b1;
        j_r <= j_r - 1'b1;
      end
      mem_path[plen_r[PathW-1:0]] <= mark_q == MK_LEFT ? {i_r, j_r - 1'b1} :
          mark_q == MK_UP ? {i_r - 1'b1, j_r} : {i_r - 1'b1, j_r - 1'b1};
      plen_r <= plen_r + 1'b1;
    end
    if (state_r == S_EMIT || (state_r == S_BT && state_nxt == S_EMIT))
      plen_r <= state_r == S_EMIT ? plen_r - 1'b1 : plen_r;
  end

  // result outputs
  always_comb begin
    out_strobe = 1'b0;
    out_item = '0;
    if (state_r == S_FINAL) begin
      out_strobe = 1'b1;
      out_item.result_kind = 1'b1;
      out_item.distance = (n1_r == '0 || n2_r == '0) ? 24'd0 : dist_r;
      out_item.status = (n1_r == '0 || n2_r == '0) ? ST_EMPTY :
                        (st_ovf_r ? ST_OVF : ST_OK);
      out_item.last = 1'b1;
    end else if (state_r == S_EMIT) begin
      out_strobe = 1'b1;
      out_item.index_first = path_q[2*IdxW-1:IdxW];
      out_item.index_second = path_q[IdxW-1:0];
    end
  end
endmodule
`default_nettype wire

// File: tb/dtw_curve_distance_with_path_unit_checker.sv
// checker for the dtw distance unit: watches the ports, predicts results, compares them
`timescale 1ns / 1ps
module dtw_curve_distance_with_path_unit_checker import dtw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        fail_count,
  output int        pending_count
);
  logic [31:0] curve_a [MaxLen];
  logic [31:0] curve_b [MaxLen];
  int          count_a;
  int          count_b;
  logic        dropped;
  logic        path_on;
  out_item_t   expected_results [$];

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b, v;
    r = 0;
    b = 64'h1 << 62;
    v = n;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] point_gap(logic [31:0] p, logic [31:0] q);
    longint dx, dy;
    dx = longint'($signed(p[31:16])) - longint'($signed(q[31:16]));
    dy = longint'($signed(p[15:0])) - longint'($signed(q[15:0]));
    return 24'(floor_root(unsigned'(dx * dx + dy * dy)));
  endfunction

  function automatic out_item_t make_result(logic rk, int i1, int i2, logic [23:0] d,
                                            logic [1:0] st, logic lst);
    out_item_t r;
    r.result_kind  = rk;
    r.index_first  = 5'(i1);
    r.index_second = 5'(i2);
    r.distance     = d;
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

  function automatic void add_expected(out_item_t r);
    expected_results = {expected_results, r};
  endfunction

  task automatic predict_warp();
    logic [23:0] acc [MaxLen][MaxLen];
    logic [1:0]  mark [MaxLen][MaxLen];
    logic [23:0] base, c, l, u, d;
    logic [24:0] s;
    logic [1:0]  st, m;
    int          n1, n2, i, j, len;
    int          path_i [PathLen];
    int          path_j [PathLen];
    n1 = count_a;
    n2 = count_b;
    st = dropped ? ST_OVF : ST_OK;
    count_a = 0;
    count_b = 0;
    dropped = 1'b0;
    if (n1 == 0 || n2 == 0) begin
      add_expected(make_result(1'b1, 0, 0, 24'd0, ST_EMPTY, 1'b1));
      return;
    end
    for (i = 0; i < n1; i++) begin
      for (j = 0; j < n2; j++) begin
        c = point_gap(curve_a[i], curve_b[j]);
        if (i == 0 && j == 0) begin
          base = 24'd0;
          m = MK_START;
        end else if (i == 0) begin
          base = acc[i][j-1];
          m = MK_LEFT;
        end else if (j == 0) begin
          base = acc[i-1][j];
          m = MK_UP;
        end else begin
          l = acc[i][j-1];
          u = acc[i-1][j];
          d = acc[i-1][j-1];
          // ties prefer left, then up
          if (l <= u && l <= d) begin
            base = l;
            m = MK_LEFT;
          end else if (u <= d) begin
            base = u;
            m = MK_UP;
          end else begin
            base = d;
            m = MK_DIAG;
          end
        end
        s = {1'b0, base} + {1'b0, c};
        acc[i][j] = s[24] ? Sat24 : s[23:0];
        mark[i][j] = m;
      end
    end
    if (path_on) begin
      i = n1 - 1;
      j = n2 - 1;
      len = 1;
      path_i[0] = i;
      path_j[0] = j;
      while (len < PathLen) begin
        m = mark[i][j];
        if (m == MK_LEFT && j > 0) j--;
        else if (m == MK_UP && i > 0) i--;
        else if (m == MK_DIAG && i > 0 && j > 0) begin
          i--;
          j--;
        end else break;
        path_i[len] = i;
        path_j[len] = j;
        len++;
      end
      for (int p = len - 1; p >= 0; p--)
        add_expected(make_result(1'b0, path_i[p], path_j[p], 24'd0, ST_OK, 1'b0));
    end
    add_expected(make_result(1'b1, 0, 0, acc[n1-1][n2-1], st, 1'b1));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      count_a = 0;
      count_b = 0;
      dropped = 1'b0;
      path_on = 1'b1;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) path_on = cfg_data;
      if (start && !busy) begin
        case (in_item.kind)
          KIND_FIRST:
            if (count_a < MaxLen) begin
              curve_a[count_a] = {in_item.coord_x, in_item.coord_y};
              count_a = count_a + 1;
            end else dropped = 1'b1;
          KIND_SECOND:
            if (count_b < MaxLen) begin
              curve_b[count_b] = {in_item.coord_x, in_item.coord_y};
              count_b = count_b + 1;
            end else dropped = 1'b1;
          KIND_COMPUTE: predict_warp();
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.result_kind !== out_item.result_kind || want.index_first !== out_item.index_first
              || want.index_second !== out_item.index_second
              || want.distance !== out_item.distance || want.status !== out_item.status
              || want.last !== out_item.last) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_item);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

// File: tb/dtw_curve_distance_with_path_unit_tb.sv
// testbench top for the dtw distance unit: clock, reset, stimulus, verdict
`timescale 1ns / 1ps
module dtw_curve_distance_with_path_unit_tb;
  import dtw_pkg::*;

  localparam int StallLimit = 100000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  int        fail_count;
  int        pending_count;
  int        quiet_cycles;
  int        loads_sent;
  int        idle_pct;

  dtw_curve_distance_with_path_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  dtw_curve_distance_with_path_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mix of full-range, small (tie-prone) and extreme coordinates
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(1023)) - 16'd512;
      1: case ($urandom_range(2))
           0: return 16'h8000;
           1: return 16'h7FFF;
           default: return 16'h0000;
         endcase
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transaction; start is left high after acceptance so back-to-back
  // items need no extra edge; each cycle is idle with probability idle_pct
  task automatic send_item(logic [1:0] kind, logic [15:0] x, logic [15:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{kind: kind, coord_x: x, coord_y: y};
    do @(posedge clk); while (busy);
    if (kind != 2'd3) loads_sent++;
  endtask

  task automatic send_point(logic [1:0] kind);
    send_item(kind, pick_coord(), pick_coord());
  endtask

  // drain every expected result, then write emit_path
  task automatic write_emit_path(logic value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one curve pair and a compute, loads of both curves interleaved at random
  task automatic warp_run(bit force_overflow);
    int n1, n2, sel;
    sel = $urandom_range(99);
    if (force_overflow || sel < 4) begin
      n1 = $urandom_range(32, 35);
      n2 = $urandom_range(1, 33);
    end else if (sel < 10) begin
      n1 = $urandom_range(0, 3);
      n2 = (n1 == 0) ? $urandom_range(0, 3) : 0;
    end else begin
      n1 = $urandom_range(1, 6);
      n2 = $urandom_range(1, 6);
    end
    while (n1 > 0 || n2 > 0) begin
      if (n2 == 0 || (n1 > 0 && $urandom_range(1))) begin
        send_point(KIND_FIRST);
        n1--;
      end else begin
        send_point(KIND_SECOND);
        n2--;
      end
    end
    send_item(KIND_COMPUTE, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_phase(int pct, int goal);
    idle_pct = pct;
    warp_run(1'b1);
    while (loads_sent < goal) begin
      if ($urandom_range(99) < 8) send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom));
      else warp_run(1'b0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    quiet_cycles = 0;
    loads_sent = 0;
    idle_pct = 30;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_emit_path(1'b1);
    // directed: both curves empty, one curve empty, extreme corners
    send_item(KIND_COMPUTE, 16'h0000, 16'h0000);
    send_item(KIND_FIRST, 16'h1234, 16'hFEDC);
    send_item(KIND_COMPUTE, 16'h0000, 16'h0000);
    send_item(KIND_FIRST, 16'h8000, 16'h8000);
    send_item(KIND_SECOND, 16'h7FFF, 16'h7FFF);
    send_item(KIND_COMPUTE, 16'hFFFF, 16'hFFFF);
    send_item(2'd3, 16'hFFFF, 16'hFFFF);  // unused kind, ignored
    // identical points everywhere: all costs zero, every choice a tie
    repeat (3) send_item(KIND_FIRST, 16'h0100, 16'hFF00);
    repeat (4) send_item(KIND_SECOND, 16'h0100, 16'hFF00);
    send_item(KIND_COMPUTE, 16'h0000, 16'h0000);
    // crossing ramps
    for (int k = 0; k < 3; k++) send_item(KIND_FIRST, 16'(k * 256), 16'h0000);
    for (int k = 0; k < 3; k++) send_item(KIND_SECOND, 16'h0000, 16'(k * 256));
    send_item(KIND_COMPUTE, 16'h0000, 16'h0000);

    random_phase(30, 160);
    write_emit_path(1'b0);
    random_phase(49, 310);
    write_emit_path(1'b1);
    random_phase(0, 460);

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/dtw_pkg.sv
rtl/core/dtw_isqrt.sv
rtl/core/dtw_curve_distance_with_path_unit.sv
tb/dtw_curve_distance_with_path_unit_checker.sv
tb/dtw_curve_distance_with_path_unit_tb.sv
